// ===== rtl/evcc_pkg.sv =====
package evcc_pkg;

  // Controller states
  localparam logic [1:0] MODE_BOOT  = 2'd0;
  localparam logic [1:0] MODE_POST  = 2'd1;
  localparam logic [1:0] MODE_RUN   = 2'd2;
  localparam logic [1:0] MODE_FAULT = 2'd3;

  // Pilot drive modes
  localparam logic [1:0] DRV_HIGH = 2'd0;
  localparam logic [1:0] DRV_LOW  = 2'd1;
  localparam logic [1:0] DRV_PWM  = 2'd2;

  // Ready modes
  localparam logic [1:0] RDY_READY = 2'd0;
  localparam logic [1:0] RDY_LIMIT = 2'd1;
  localparam logic [1:0] RDY_SLEEP = 2'd2;

  // Request codes
  localparam logic [2:0] REQ_POLL   = 3'd0;
  localparam logic [2:0] REQ_RELAY  = 3'd1;
  localparam logic [2:0] REQ_GFCI   = 3'd2;
  localparam logic [2:0] REQ_AMPS   = 3'd3;
  localparam logic [2:0] REQ_READY  = 3'd4;
  localparam logic [2:0] REQ_TEMP   = 3'd5;
  localparam logic [2:0] REQ_TICK   = 3'd6;

  // Measured pilot codes
  localparam logic [3:0] PIL_A       = 4'd0;
  localparam logic [3:0] PIL_B       = 4'd1;
  localparam logic [3:0] PIL_C       = 4'd2;
  localparam logic [3:0] PIL_D       = 4'd3;
  localparam logic [3:0] PIL_E       = 4'd4;
  localparam logic [3:0] PIL_NRDY    = 4'd5;
  localparam logic [3:0] PIL_DIODE   = 4'd6;
  localparam logic [3:0] PIL_UNKNOWN = 4'd7;
  localparam logic [3:0] PIL_IMPL    = 4'd8;

  // Relay check codes
  localparam logic [1:0] RST_OK      = 2'd0;
  localparam logic [1:0] RST_UNKNOWN = 2'd1;
  localparam logic [1:0] RST_NOGND   = 2'd2;
  localparam logic [1:0] RST_STUCK   = 2'd3;

  // Fault codes
  localparam logic [2:0] FLT_NONE  = 3'd0;
  localparam logic [2:0] FLT_POST  = 3'd1;
  localparam logic [2:0] FLT_NOGND = 3'd2;
  localparam logic [2:0] FLT_STUCK = 3'd3;
  localparam logic [2:0] FLT_GFCI  = 3'd4;
  localparam logic [2:0] FLT_TEMP  = 3'd5;

  localparam logic [6:0]  AMPS_MAX    = 7'd80;
  localparam logic [15:0] DELAY_RESET = 16'd3000;

  localparam int IN_W  = 24;
  localparam int OUT_W = 24;

  // Controller state record
  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  fault;
    logic [3:0]  last_pilot;
    logic [1:0]  ready;
    logic [6:0]  amps_limit;
    logic [1:0]  drive;
    logic [6:0]  drive_amps;
    logic        relay;
    logic        sleep;
    logic [15:0] delay_cnt;
    logic        delay_pend;
  } st_t;

  // Decoded input item
  typedef struct packed {
    logic [2:0] req;
    logic [3:0] pilot;
    logic [1:0] rstat;
    logic       gfci_ok;
    logic       param;
    logic [6:0] amps;
    logic [1:0] rdy;
  } item_t;

  localparam st_t ST_RESET = '{
    mode:       MODE_BOOT,
    fault:      FLT_NONE,
    last_pilot: PIL_UNKNOWN,
    ready:      RDY_READY,
    amps_limit: 7'd0,
    drive:      DRV_HIGH,
    drive_amps: 7'd0,
    relay:      1'b0,
    sleep:      1'b0,
    delay_cnt:  16'd0,
    delay_pend: 1'b0
  };

endpackage

// ===== rtl/evse_charge_controller.sv =====
// Channel | Dir | Handshake                | Payload
// in_     | in  | in_tvalid / in_tready    | in_tuser: req_type; in_tdata: pilot/relay/amps fields
// out_    | out | out_tvalid / out_tready  | out_tdata: relay, pilot drive, amps, status
// cfg_    | in  | cfg_valid / cfg_ready    | cfg_data: relay_suspend_delay
//
// One item per cycle while no result is stalled: an accepted item updates the controller
// state and the result register at the same edge; its result shows on the next cycle.
// The only path is the event decode in evcc_core between state and result.
// Reset (rst_n low, synchronous) loads the default state and a delay of 3000.
// A stalled result holds; in_tready drops only while it is not taken.
module evse_charge_controller
  import evcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [2:0]         in_tuser,   // [2:0] req_type
  input  logic [IN_W-1:0]    in_tdata,   // [3:0] pilot_state, [5:4] relay_status,
                                         // [6] gfci_test_ok, [7] event_param,
                                         // [14:8] new_max_amps, [16:15] new_ready
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_W-1:0]   out_tdata,  // [0] relay_closed, [2:1] pilot_mode,
                                         // [9:3] pwm_amps, [11:10] controller_state,
                                         // [14:12] fault_code, [18:15] pilot_state_seen,
                                         // [19] sleep_flag
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  st_t         state_r;
  st_t         state_nxt;
  item_t       item;
  logic [15:0] delay_cfg_r;
  logic        out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic [OUT_W-1:0] out_data_nxt;
  logic        in_acc;
  logic [6:0]  pwm_amps;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // Unpack the item
  assign item.req     = in_tuser;
  assign item.pilot   = in_tdata[3:0];
  assign item.rstat   = in_tdata[5:4];
  assign item.gfci_ok = in_tdata[6];
  assign item.param   = in_tdata[7];
  assign item.amps    = in_tdata[14:8];
  assign item.rdy     = in_tdata[16:15];

  evcc_core u_core (
    .cur           (state_r),
    .item          (item),
    .suspend_delay (delay_cfg_r),
    .nxt           (state_nxt)
  );

  // Pack the result from the updated state
  assign pwm_amps     = (state_nxt.drive == DRV_PWM) ? state_nxt.drive_amps : 7'd0;
  assign out_data_nxt = {4'd0, state_nxt.sleep, state_nxt.last_pilot, state_nxt.fault,
                         state_nxt.mode, pwm_amps, state_nxt.drive, state_nxt.relay};

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_cfg_r <= DELAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      delay_cfg_r <= cfg_data;
    end
  end

  // Controller state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/evcc_core.sv =====
module evcc_core
  import evcc_pkg::*;
(
  input  st_t         cur,
  input  item_t       item,
  input  logic [15:0] suspend_delay,
  output st_t         nxt
);

  function automatic st_t latch_fault(st_t s, logic [2:0] code);
    st_t r;
    r = s;
    r.relay = 1'b0;
    r.drive = DRV_LOW;
    r.fault = code;
    r.mode  = MODE_FAULT;
    return r;
  endfunction

  function automatic st_t set_relay(st_t s, logic on, logic gfci_ok);
    st_t r;
    r = s;
    if (on && gfci_ok) begin
      r.relay = 1'b1;
    end else if (on) begin
      r = latch_fault(s, FLT_POST);
    end else begin
      r.relay = 1'b0;
    end
    return r;
  endfunction

  function automatic st_t apply_amps(st_t s, logic start_pwm);
    st_t r;
    r = s;
    if (s.amps_limit == 7'd0) begin
      r.drive = DRV_HIGH;
    end else if (start_pwm || s.drive == DRV_PWM) begin
      r.drive      = DRV_PWM;
      r.drive_amps = s.amps_limit;
    end
    return r;
  endfunction

  // One running step: relay check, then act on a pilot change or a forced rerun
  function automatic st_t run_step(st_t s, logic [3:0] pilot, logic [1:0] rstat,
                                   logic force_run, logic gfci_ok,
                                   logic [15:0] dly);
    st_t r;
    r = s;
    if (rstat == RST_NOGND) begin
      r = latch_fault(s, FLT_NOGND);
    end else if (rstat == RST_STUCK) begin
      r = latch_fault(s, FLT_STUCK);
    end else if (s.last_pilot != pilot || force_run) begin
      case (pilot)
        PIL_E: begin
          r = set_relay(r, 1'b0, gfci_ok);
        end
        PIL_A, PIL_NRDY: begin
          if (r.ready == RDY_LIMIT) r.ready = RDY_READY;
          r = set_relay(r, 1'b0, gfci_ok);
          r.drive = DRV_HIGH;
        end
        PIL_B, PIL_D, PIL_DIODE: begin
          r = set_relay(r, 1'b0, gfci_ok);
          r.delay_pend = 1'b0;
          r.delay_cnt  = 16'd0;
          if (r.ready == RDY_READY) r = apply_amps(r, 1'b1);
          else r.drive = DRV_HIGH;
        end
        PIL_C: begin
          if (r.ready == RDY_READY) begin
            r = apply_amps(r, 1'b1);
            r = set_relay(r, 1'b1, gfci_ok);
          end else begin
            r.drive      = DRV_HIGH;
            r.delay_pend = 1'b1;
            r.delay_cnt  = dly;
          end
        end
        default: begin
          r = set_relay(r, 1'b0, gfci_ok);
          r.drive = DRV_LOW;
        end
      endcase
      r.last_pilot = pilot;
    end
    return r;
  endfunction

  logic [3:0] pilot_sat;
  logic [6:0] amps_sat;
  logic [1:0] rdy_sat;

  // Clamp out-of-range codes
  assign pilot_sat = (item.pilot > PIL_IMPL) ? PIL_IMPL : item.pilot;
  assign amps_sat  = (item.amps > AMPS_MAX) ? AMPS_MAX : item.amps;
  assign rdy_sat   = (item.rdy == 2'd3) ? RDY_SLEEP : item.rdy;

  // Event dispatch
  always_comb begin
    nxt = cur;
    case (item.req)
      REQ_POLL: begin
        if (cur.mode == MODE_RUN) begin
          nxt = run_step(cur, pilot_sat, item.rstat, 1'b0, item.gfci_ok, suspend_delay);
        end else if (cur.mode == MODE_BOOT) begin
          nxt.mode = MODE_POST;
        end else if (cur.mode == MODE_POST) begin
          if (!item.gfci_ok) begin
            nxt = latch_fault(cur, FLT_POST);
          end else begin
            nxt.drive = DRV_HIGH;
            nxt.mode  = MODE_RUN;
          end
        end
      end
      REQ_RELAY: begin
        nxt = set_relay(cur, item.param, item.gfci_ok);
      end
      REQ_GFCI: begin
        nxt = latch_fault(cur, FLT_GFCI);
      end
      REQ_AMPS: begin
        nxt.amps_limit = amps_sat;
        nxt = apply_amps(nxt, 1'b0);
      end
      REQ_READY: begin
        nxt.ready = rdy_sat;
        if (cur.mode == MODE_RUN) begin
          nxt.sleep = (rdy_sat != RDY_READY);
          nxt = run_step(nxt, pilot_sat, item.rstat, 1'b1, item.gfci_ok, suspend_delay);
        end
      end
      REQ_TEMP: begin
        if (item.param) nxt = latch_fault(cur, FLT_TEMP);
        else nxt = apply_amps(cur, 1'b0);
      end
      REQ_TICK: begin
        if (cur.delay_pend) begin
          if (cur.delay_cnt <= 16'd1) begin
            nxt.delay_pend = 1'b0;
            nxt.delay_cnt  = 16'd0;
            nxt = set_relay(nxt, 1'b0, item.gfci_ok);
          end else begin
            nxt.delay_cnt = cur.delay_cnt - 16'd1;
          end
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// ===== rtl/evcc_checker.sv =====
module evcc_checker
  import evcc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [2:0]       in_tuser,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // A held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Input stalls only behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a stalled result");

  // Advertised amps are zero unless the pilot is pwm
  a_pwm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:1] != DRV_PWM |-> out_tdata[9:3] == 7'd0)
    else $error("pwm amps shown outside pwm mode");

  // Fault state and a nonzero fault code go together
  a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[11:10] == MODE_FAULT) == (out_tdata[14:12] != FLT_NONE)))
    else $error("fault state and fault code disagree");

  // A ground-fault trip latches its fault
  a_gfci_trip: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == REQ_GFCI |=>
      out_tvalid && out_tdata[11:10] == MODE_FAULT && out_tdata[14:12] == FLT_GFCI
      && out_tdata[0] == 1'b0)
    else $error("gfci trip not latched");

endmodule

bind evse_charge_controller evcc_checker u_evcc_checker (.*);

// ===== bench/evse_charge_controller_tb.sv =====
module evse_charge_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import evcc_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int LIMIT_CYCLES = 600000;
  localparam int MAX_REPORTS = 50;

  // codes outside the documented ranges
  localparam logic [2:0] REQ_SPARE = 3'd7;
  localparam logic [3:0] PIL_TOP = 4'hF;
  localparam logic [1:0] RDY_SPARE = 2'd3;
  localparam logic [6:0] AMPS_TOP = 7'd127;

  // one event item as the sender sees it
  typedef struct packed {
    logic [2:0] req;
    logic [3:0] pilot;
    logic [1:0] rstat;
    logic       gfci;
    logic       param;
    logic [6:0] amps;
    logic [1:0] rdy;
  } evt_t;

  // one status item as the receiver sees it
  typedef struct packed {
    logic       relay;
    logic [1:0] drive;
    logic [6:0] pwm;
    logic [1:0] mode;
    logic [2:0] fault;
    logic [3:0] pilot;
    logic       sleep;
  } status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [2:0] in_tuser = '0;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  evse_charge_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // controller state as the testbench tracks it
  logic [1:0]  ev_mode;
  logic [2:0]  ev_fault;
  logic [3:0]  ev_pilot;
  logic [1:0]  ev_ready;
  logic [6:0]  ev_amps_lim;
  logic [1:0]  ev_drive;
  logic [6:0]  ev_drv_amps;
  logic        ev_relay;
  logic        ev_sleep;
  logic [15:0] ev_sus_cnt;
  logic        ev_sus_pend;
  logic        gfci_pass;
  logic [15:0] sus_delay;

  evt_t    event_q[$];
  status_t status_due_q[$];
  evt_t    cur_event;
  int      launched = 0;
  int      accepted = 0;
  int      results_seen = 0;
  int      err_count = 0;
  int      send_gap = 0;
  int      hold_left = 0;
  logic    long_done = 1'b0;
  logic    quiet = 1'b0;

  // ---------------- status prediction ----------------

  function automatic void trip(logic [2:0] code);
    ev_relay = 1'b0;
    ev_drive = DRV_LOW;
    ev_fault = code;
    ev_mode = MODE_FAULT;
  endfunction

  function automatic void drive_relay(logic on);
    if (on && gfci_pass) begin
      ev_relay = 1'b1;
    end else if (on) begin
      trip(FLT_POST);
    end else begin
      ev_relay = 1'b0;
    end
  endfunction

  function automatic void refresh_pwm(logic start);
    if (ev_amps_lim == '0) begin
      ev_drive = DRV_HIGH;
    end else if (start || ev_drive == DRV_PWM) begin
      ev_drive = DRV_PWM;
      ev_drv_amps = ev_amps_lim;
    end
  endfunction

  // running step: relay check first, then act on a pilot change or a forced redo
  function automatic void run_pilot(logic [3:0] pil, logic [1:0] rs, logic redo);
    if (rs == RST_NOGND) begin
      trip(FLT_NOGND);
      return;
    end
    if (rs == RST_STUCK) begin
      trip(FLT_STUCK);
      return;
    end
    if (ev_pilot == pil && !redo)
      return;
    case (pil)
      PIL_E: begin
        drive_relay(1'b0);
      end
      PIL_A, PIL_NRDY: begin
        if (ev_ready == RDY_LIMIT)
          ev_ready = RDY_READY;
        drive_relay(1'b0);
        ev_drive = DRV_HIGH;
      end
      PIL_B, PIL_D, PIL_DIODE: begin
        drive_relay(1'b0);
        ev_sus_pend = 1'b0;
        ev_sus_cnt = '0;
        if (ev_ready == RDY_READY)
          refresh_pwm(1'b1);
        else
          ev_drive = DRV_HIGH;
      end
      PIL_C: begin
        if (ev_ready == RDY_READY) begin
          refresh_pwm(1'b1);
          drive_relay(1'b1);
        end else begin
          // suspended charge: open the relay after the programmed ticks
          ev_drive = DRV_HIGH;
          ev_sus_pend = 1'b1;
          ev_sus_cnt = sus_delay;
        end
      end
      default: begin
        drive_relay(1'b0);
        ev_drive = DRV_LOW;
      end
    endcase
    ev_pilot = pil;
  endfunction

  function automatic status_t evse_next_status(evt_t e);
    logic [3:0] pil;
    logic [6:0] amps;
    logic [1:0] rdy;
    status_t s;
    gfci_pass = e.gfci;
    pil = (e.pilot > PIL_IMPL) ? PIL_IMPL : e.pilot;
    amps = (e.amps > AMPS_MAX) ? AMPS_MAX : e.amps;
    rdy = (e.rdy > RDY_SLEEP) ? RDY_SLEEP : e.rdy;
    case (e.req)
      REQ_POLL: begin
        if (ev_mode == MODE_RUN) begin
          run_pilot(pil, e.rstat, 1'b0);
        end else if (ev_mode == MODE_BOOT) begin
          ev_mode = MODE_POST;
        end else if (ev_mode == MODE_POST) begin
          if (!gfci_pass) begin
            trip(FLT_POST);
          end else begin
            ev_drive = DRV_HIGH;
            ev_mode = MODE_RUN;
          end
        end
      end
      REQ_RELAY: drive_relay(e.param);
      REQ_GFCI: trip(FLT_GFCI);
      REQ_AMPS: begin
        ev_amps_lim = amps;
        refresh_pwm(1'b0);
      end
      REQ_READY: begin
        ev_ready = rdy;
        if (ev_mode == MODE_RUN) begin
          ev_sleep = (ev_ready != RDY_READY);
          run_pilot(pil, e.rstat, 1'b1);
        end
      end
      REQ_TEMP: begin
        if (e.param)
          trip(FLT_TEMP);
        else
          refresh_pwm(1'b0);
      end
      REQ_TICK: begin
        if (ev_sus_pend) begin
          if (ev_sus_cnt <= 16'd1) begin
            ev_sus_pend = 1'b0;
            ev_sus_cnt = '0;
            drive_relay(1'b0);
          end else begin
            ev_sus_cnt = ev_sus_cnt - 16'd1;
          end
        end
      end
      default: ;
    endcase
    s.relay = ev_relay;
    s.drive = ev_drive;
    s.pwm = (ev_drive == DRV_PWM) ? ev_drv_amps : '0;
    s.mode = ev_mode;
    s.fault = ev_fault;
    s.pilot = ev_pilot;
    s.sleep = ev_sleep;
    return s;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic evt_t mk(logic [2:0] rq, logic [3:0] pil, logic [1:0] rs, logic gf,
                              logic pa, logic [6:0] am, logic [1:0] rd);
    evt_t e;
    e.req = rq;
    e.pilot = pil;
    e.rstat = rs;
    e.gfci = gf;
    e.param = pa;
    e.amps = am;
    e.rdy = rd;
    return e;
  endfunction

  function automatic void post(evt_t e);
    event_q.push_back(e);
    launched++;
  endfunction

  // any field value at all
  function automatic evt_t noise_event();
    return mk(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              7'($urandom_range(0, 127)), 2'($urandom_range(0, 3)));
  endfunction

  // random event that never latches a fault, so the controller keeps running
  function automatic evt_t calm_event();
    evt_t e;
    int r;
    e = noise_event();
    r = $urandom_range(99);
    if (r < 35)      e.req = REQ_POLL;
    else if (r < 60) e.req = REQ_TICK;
    else if (r < 68) e.req = REQ_RELAY;
    else if (r < 78) e.req = REQ_AMPS;
    else if (r < 90) e.req = REQ_READY;
    else if (r < 95) e.req = REQ_TEMP;
    else             e.req = REQ_SPARE;
    r = $urandom_range(99);
    if (r < 30)      e.pilot = PIL_C;
    else if (r < 92) e.pilot = 4'($urandom_range(0, 8));
    r = $urandom_range(99);
    if (r < 15)      e.amps = '0;
    else if (r < 85) e.amps = 7'($urandom_range(1, 80));
    if ($urandom_range(1))
      e.rdy = RDY_READY;
    if (e.req == REQ_POLL || e.req == REQ_READY) begin
      e.rstat = 2'($urandom_range(0, 1));
      e.gfci = 1'b1;
    end
    if (e.req == REQ_RELAY && e.param)
      e.gfci = 1'b1;
    if (e.req == REQ_TEMP)
      e.param = 1'b0;
    return e;
  endfunction

  // idle length for either side: mostly short, sometimes long
  function automatic int idle_len();
    int r;
    if (quiet)
      return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void cmp_field(string nm, int unsigned want, int unsigned got);
    if (want != got) begin
      if (err_count < MAX_REPORTS)
        $display("%0t: %s expected %0d got %0d", $realtime, nm, want, got);
      err_count++;
    end
  endfunction

  // every sent item taken and every status item received
  task automatic wait_drained();
    while (accepted != launched || status_due_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_delay(logic [15:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready))
      @(posedge clk);
    sus_delay = v;
    cfg_valid <= 1'b0;
  endtask

  // ---------------- event driver ----------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        status_due_q.push_back(evse_next_status(cur_event));
        accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (event_q.size() > 0) begin
          cur_event = event_q.pop_front();
          in_tuser <= cur_event.req;
          in_tdata <= {{(IN_W - 17){1'b0}}, cur_event.rdy, cur_event.amps, cur_event.param,
                       cur_event.gfci, cur_event.rstat, cur_event.pilot};
          in_tvalid <= 1'b1;
          send_gap = idle_len();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- status monitor ----------------
  always @(posedge clk) begin
    status_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (status_due_q.size() == 0) begin
          if (err_count < MAX_REPORTS)
            $display("%0t: status item with none expected, got %h", $realtime, out_tdata);
          err_count++;
        end else begin
          want = status_due_q.pop_front();
          cmp_field("relay_closed", want.relay, out_tdata[0]);
          cmp_field("pilot_mode", want.drive, out_tdata[2:1]);
          cmp_field("pwm_amps", want.pwm, out_tdata[9:3]);
          cmp_field("controller_state", want.mode, out_tdata[11:10]);
          cmp_field("fault_code", want.fault, out_tdata[14:12]);
          cmp_field("pilot_state_seen", want.pilot, out_tdata[18:15]);
          cmp_field("sleep_flag", want.sleep, out_tdata[19]);
        end
      end
      // backpressure; one long hold so the block fills and stalls its input
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!long_done && results_seen >= 400) begin
        long_done = 1'b1;
        hold_left = 300;
        out_tready <= 1'b0;
      end else begin
        hold_left = idle_len();
        out_tready <= (hold_left == 0);
      end
    end
  end

  // ---------------- stimulus sequence ----------------
  initial begin
    logic [15:0] delay_set[6];
    ev_mode = MODE_BOOT;
    ev_fault = FLT_NONE;
    ev_pilot = PIL_UNKNOWN;
    ev_ready = RDY_READY;
    ev_amps_lim = '0;
    ev_drive = DRV_HIGH;
    ev_drv_amps = '0;
    ev_relay = 1'b0;
    ev_sleep = 1'b0;
    ev_sus_cnt = '0;
    ev_sus_pend = 1'b0;
    gfci_pass = 1'b0;
    sus_delay = DELAY_RESET;

    // boot-time events, then the path into running
    post(mk(REQ_TICK, PIL_A, RST_OK, 1'b0, 1'b0, '0, RDY_READY));
    post(mk(REQ_AMPS, PIL_A, RST_OK, 1'b0, 1'b0, AMPS_TOP, RDY_READY));
    post(mk(REQ_RELAY, PIL_A, RST_OK, 1'b1, 1'b1, '0, RDY_READY));
    post(mk(REQ_RELAY, PIL_A, RST_OK, 1'b1, 1'b0, '0, RDY_READY));
    post(mk(REQ_SPARE, PIL_TOP, RST_STUCK, 1'b1, 1'b1, AMPS_TOP, RDY_SPARE));
    post(mk(REQ_TEMP, PIL_A, RST_OK, 1'b0, 1'b0, '0, RDY_READY));
    post(mk(REQ_READY, PIL_C, RST_OK, 1'b1, 1'b0, '0, RDY_SPARE));
    post(mk(REQ_POLL, PIL_A, RST_OK, 1'b1, 1'b0, '0, RDY_READY));
    post(mk(REQ_READY, PIL_A, RST_OK, 1'b1, 1'b0, '0, RDY_READY));
    post(mk(REQ_POLL, PIL_A, RST_OK, 1'b1, 1'b0, '0, RDY_READY));
    // running: out-of-range pilot, pwm start, amps to zero and back
    post(mk(REQ_POLL, PIL_TOP, RST_UNKNOWN, 1'b1, 1'b0, '0, RDY_READY));
    post(mk(REQ_POLL, PIL_B, RST_OK, 1'b1, 1'b0, '0, RDY_READY));
    post(mk(REQ_AMPS, PIL_B, RST_OK, 1'b1, 1'b0, '0, RDY_READY));
    post(mk(REQ_AMPS, PIL_B, RST_OK, 1'b1, 1'b0, 7'd32, RDY_READY));
    post(mk(REQ_POLL, PIL_C, RST_OK, 1'b1, 1'b0, '0, RDY_READY));
    post(mk(REQ_POLL, PIL_C, RST_OK, 1'b1, 1'b0, '0, RDY_READY));
    // suspended charge, countdown, then pilot changes
    post(mk(REQ_READY, PIL_C, RST_OK, 1'b1, 1'b0, '0, RDY_LIMIT));
    post(mk(REQ_TICK, PIL_C, RST_OK, 1'b1, 1'b0, '0, RDY_READY));
    post(mk(REQ_POLL, PIL_A, RST_OK, 1'b1, 1'b0, '0, RDY_READY));
    post(mk(REQ_READY, PIL_E, RST_OK, 1'b1, 1'b0, '0, RDY_READY));
    post(mk(REQ_POLL, PIL_DIODE, RST_OK, 1'b1, 1'b0, '0, RDY_READY));
    post(mk(REQ_TEMP, PIL_DIODE, RST_OK, 1'b1, 1'b0, '0, RDY_READY));
    post(mk(REQ_POLL, PIL_NRDY, RST_OK, 1'b1, 1'b0, '0, RDY_READY));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // random phases over a range of suspend delays, extremes included
    delay_set[0] = 16'd0;
    delay_set[1] = 16'd1;
    delay_set[2] = 16'($urandom_range(2, 6));
    delay_set[3] = 16'hFFFF;
    delay_set[4] = 16'($urandom_range(2, 12));
    delay_set[5] = 16'($urandom_range(2, 4));
    for (int ph = 0; ph < 6; ph++) begin
      write_delay(delay_set[ph]);
      quiet = (ph == 2);
      @(negedge clk);
      repeat (135) post(calm_event());
    end

    // faults last, since they latch for good; then anything goes
    wait_drained();
    quiet = 1'b0;
    @(negedge clk);
    post(mk(REQ_POLL, 4'($urandom_range(0, 8)), 2'($urandom_range(2, 3)), 1'b1, 1'b0, '0,
            RDY_READY));
    post(mk(REQ_GFCI, PIL_A, RST_OK, 1'b1, 1'b0, '0, RDY_READY));
    post(mk(REQ_TEMP, PIL_A, RST_OK, 1'b1, 1'b1, '0, RDY_READY));
    post(mk(REQ_RELAY, PIL_A, RST_OK, 1'b0, 1'b1, '0, RDY_READY));
    repeat (150) post(noise_event());

    wait_drained();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("TB_ERROR");
    $finish;
  end

endmodule
